@@ sv/icbv_pkg.sv @@
// ----------------------------------------------------------------------------
// icbv_pkg
// shared constants and types for the interleaved crc block verifier
// ----------------------------------------------------------------------------
package icbv_pkg;

  localparam int unsigned MaxHashWordsDef    = 1024;
  localparam int unsigned BlockNumberBitsDef = 48;
  localparam int unsigned AddrW              = 49;
  localparam int unsigned CfgW               = 49;
  localparam int unsigned PosW               = 10;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindFill  = 2'd1;
  localparam logic [1:0] KindData  = 2'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatMismatch = 2'd1;
  localparam logic [1:0] StatRange    = 2'd2;
  localparam logic [1:0] StatHashFail = 2'd3;

  localparam logic [1:0] RegWordsPerBlock = 2'd0;
  localparam logic [1:0] RegZeroCrc       = 2'd1;
  localparam logic [1:0] RegBlockCount    = 2'd2;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv   = 6'b000010,
    StFin   = 6'b000100,
    StSweep = 6'b001000,
    StStore = 6'b010000,
    StCmp   = 6'b100000
  } state_e;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ sv/interleaved_crc_block_verifier.sv @@
// ----------------------------------------------------------------------------
// interleaved_crc_block_verifier
// maps a logical block to its hash and data block, keeps a one-block hash
// cache and checks or produces the crc-32 word of each data block
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o, one transaction is a start, a hash
// word fill or a data byte (kind_i). output channel: out_valid_o /
// out_stall_i, one transaction per result held in an output register.
// a start in range runs a bit-serial restoring divider, one quotient bit per cycle,
// then StFin registers its result; no input is taken meanwhile.
// the crc runs one byte a cycle while the input channel is not stalled.
// the last byte of a read that hits the cache goes through StCmp (cache memory read port).
// a failed fill on a write, or a write end that misses the cache, zeroes
// the cache memory one word a cycle, all MAX_HASH_WORDS words; a write end
// then stores the new word in StStore.
// input is taken only when idle and the output register is free or being
// emptied, so a stalled receiver holds back the input channel too.
// reset clears control state, config registers and the cache tag; the cache
// words themselves are not cleared.
// ----------------------------------------------------------------------------
module interleaved_crc_block_verifier import icbv_pkg::*; #(
  parameter int unsigned MAX_HASH_WORDS    = MaxHashWordsDef,
  parameter int unsigned BLOCK_NUMBER_BITS = BlockNumberBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic                         is_write_i,
  input  logic [BLOCK_NUMBER_BITS-1:0] logical_block_i,
  input  logic [9:0]                   fill_index_i,
  input  logic [31:0]                  fill_value_i,
  input  logic                         fill_failed_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         data_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic                         fetch_needed_o,
  output logic [AddrW-1:0]             hash_block_address_o,
  output logic [AddrW-1:0]             data_block_address_o,
  output logic [PosW-1:0]              word_position_o,
  output logic [31:0]                  stored_word_o,
  output logic                         access_done_o
);

  localparam int unsigned AW  = (MAX_HASH_WORDS > 1) ? $clog2(MAX_HASH_WORDS) : 1;
  localparam int unsigned MW  = $clog2(MAX_HASH_WORDS + 1);
  localparam int unsigned WW  = (MW > 11) ? MW : 11;
  localparam int unsigned BN  = BLOCK_NUMBER_BITS;
  localparam int unsigned LW  = ((BN > AddrW) ? BN : AddrW) + 2;
  localparam int unsigned CW  = $clog2(BN + 1);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_HASH_WORDS - 1);
  localparam logic [CW-1:0] LastBit = CW'(BN - 1);

  logic [10:0]       wpb_q;
  logic [31:0]       zero_q;
  logic [AddrW-1:0]  count_q;

  state_e            state_q, state_d;
  logic              active_q, active_d;
  logic              wr_q, wr_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AddrW-1:0]  pend_q, pend_d;
  logic [AddrW-1:0]  daddr_q, daddr_d;
  logic [AddrW-1:0]  cached_q, cached_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       word_q, word_d;
  logic              end_q, end_d;
  logic [AW-1:0]     sw_q, sw_d;

  logic [BN-1:0]     lb_q, lb_d;
  logic [BN-1:0]     dvd_q, dvd_d;
  logic [WW-1:0]     rem_q, rem_d;
  logic [WW-1:0]     dvs_q, dvs_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  logic              ov_q, ov_d;
  logic [1:0]        st_q, st_d;
  logic              fn_q, fn_d;
  logic [AddrW-1:0]  oh_q, oh_d;
  logic [AddrW-1:0]  od_q, od_d;
  logic [PosW-1:0]   op_q, op_d;
  logic [31:0]       ow_q, ow_d;
  logic              done_q, done_d;

  logic [31:0]       mem [MAX_HASH_WORDS];
  logic [31:0]       rdata_q;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [31:0]       wdata;

  logic              slot_free, accept;
  logic [WW-1:0]     wpb_eff;
  logic [WW:0]       trial;
  logic [LW-1:0]     haddr_w, daddr_w;
  logic [31:0]       crc_next;

  assign slot_free  = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (wpb_q == 11'd0) begin
      wpb_eff = WW'(1);
    end else if (32'(wpb_q) > 32'(MAX_HASH_WORDS)) begin
      wpb_eff = WW'(MAX_HASH_WORDS);
    end else begin
      wpb_eff = WW'(wpb_q);
    end
  end

  assign trial    = {rem_q, dvd_q[BN-1]};
  assign haddr_w  = LW'(lb_q) - LW'(rem_q) + LW'(dvd_q);
  assign daddr_w  = LW'(lb_q) + LW'(dvd_q) + LW'(1);
  assign crc_next = crc_byte(crc_q, data_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpb_q   <= 11'd1024;
      zero_q  <= '0;
      count_q <= AddrW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWordsPerBlock: wpb_q   <= cfg_data_i[10:0];
        RegZeroCrc:       zero_q  <= cfg_data_i[31:0];
        RegBlockCount:    count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    wr_d     = wr_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    daddr_d  = daddr_q;
    cached_d = cached_q;
    crc_d    = crc_q;
    word_d   = word_q;
    end_d    = end_q;
    sw_d     = sw_q;
    lb_d     = lb_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    cnt_d    = cnt_q;
    ov_d     = ov_q && out_stall_i;
    st_d     = st_q;
    fn_d     = fn_q;
    oh_d     = oh_q;
    od_d     = od_q;
    op_d     = op_q;
    ow_d     = ow_q;
    done_d   = done_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = word_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (kind_i == KindStart) begin
            crc_d = '1;
            if (LW'(logical_block_i) >= LW'(count_q)) begin
              active_d = 1'b0;
              ov_d     = 1'b1;
              st_d     = StatRange;
              fn_d     = 1'b0;
              oh_d     = '0;
              od_d     = '0;
              op_d     = '0;
              ow_d     = '0;
              done_d   = 1'b1;
            end else begin
              wr_d    = is_write_i;
              lb_d    = logical_block_i;
              dvd_d   = logical_block_i;
              rem_d   = '0;
              dvs_d   = wpb_eff;
              cnt_d   = '0;
              state_d = StDiv;
            end
          end else if (active_q && kind_i == KindFill) begin
            if (fill_failed_i) begin
              if (wr_q) begin
                cached_d = pend_q;
                end_d    = 1'b0;
                sw_d     = '0;
                state_d  = StSweep;
              end else begin
                cached_d = '1;
                active_d = 1'b0;
                crc_d    = '1;
                ov_d     = 1'b1;
                st_d     = StatHashFail;
                fn_d     = 1'b0;
                oh_d     = pend_q;
                od_d     = daddr_q;
                op_d     = PosW'(pos_q);
                ow_d     = '0;
                done_d   = 1'b1;
              end
            end else begin
              if (32'(fill_index_i) < 32'(MAX_HASH_WORDS)) begin
                we    = 1'b1;
                waddr = AW'(fill_index_i);
                wdata = fill_value_i;
              end
              cached_d = pend_q;
            end
          end else if (active_q && kind_i == KindData) begin
            crc_d = crc_next;
            if (data_last_i) begin
              active_d = 1'b0;
              crc_d    = '1;
              word_d   = ~crc_next ^ zero_q;
              if (wr_q) begin
                if (cached_q != pend_q) begin
                  cached_d = pend_q;
                  end_d    = 1'b1;
                  sw_d     = '0;
                  state_d  = StSweep;
                end else begin
                  we      = 1'b1;
                  wdata   = ~crc_next ^ zero_q;
                  ov_d    = 1'b1;
                  st_d    = StatOk;
                  fn_d    = 1'b0;
                  oh_d    = pend_q;
                  od_d    = daddr_q;
                  op_d    = PosW'(pos_q);
                  ow_d    = ~crc_next ^ zero_q;
                  done_d  = 1'b1;
                end
              end else if (cached_q != pend_q) begin
                ov_d   = 1'b1;
                st_d   = StatHashFail;
                fn_d   = 1'b0;
                oh_d   = pend_q;
                od_d   = daddr_q;
                op_d   = PosW'(pos_q);
                ow_d   = '0;
                done_d = 1'b1;
              end else begin
                state_d = StCmp;
              end
            end
          end
        end
      end
      StDiv: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = WW'(trial - {1'b0, dvs_q});
          dvd_d = {dvd_q[BN-2:0], 1'b1};
        end else begin
          rem_d = trial[WW-1:0];
          dvd_d = {dvd_q[BN-2:0], 1'b0};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LastBit) begin
          state_d = StFin;
        end
      end
      StFin: begin
        pos_d    = AW'(rem_q);
        pend_d   = haddr_w[AddrW-1:0];
        daddr_d  = daddr_w[AddrW-1:0];
        active_d = 1'b1;
        ov_d     = 1'b1;
        st_d     = StatOk;
        fn_d     = cached_q != haddr_w[AddrW-1:0];
        oh_d     = haddr_w[AddrW-1:0];
        od_d     = daddr_w[AddrW-1:0];
        op_d     = PosW'(rem_q);
        ow_d     = '0;
        done_d   = 1'b0;
        state_d  = StIdle;
      end
      StSweep: begin
        we    = 1'b1;
        waddr = sw_q;
        wdata = '0;
        sw_d  = sw_q + AW'(1);
        if (sw_q == LastIdx) begin
          state_d = end_q ? StStore : StIdle;
        end
      end
      StStore: begin
        we      = 1'b1;
        ov_d    = 1'b1;
        st_d    = StatOk;
        fn_d    = 1'b0;
        oh_d    = pend_q;
        od_d    = daddr_q;
        op_d    = PosW'(pos_q);
        ow_d    = word_q;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StCmp: begin
        ov_d    = 1'b1;
        st_d    = (rdata_q == word_q) ? StatOk : StatMismatch;
        fn_d    = 1'b0;
        oh_d    = pend_q;
        od_d    = daddr_q;
        op_d    = PosW'(pos_q);
        ow_d    = '0;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      active_q <= 1'b0;
      wr_q     <= 1'b0;
      pos_q    <= '0;
      pend_q   <= '1;
      daddr_q  <= '0;
      cached_q <= '1;
      crc_q    <= '1;
      end_q    <= 1'b0;
      sw_q     <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      wr_q     <= wr_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      daddr_q  <= daddr_d;
      cached_q <= cached_d;
      crc_q    <= crc_d;
      end_q    <= end_d;
      sw_q     <= sw_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    lb_q   <= lb_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    st_q   <= st_d;
    fn_q   <= fn_d;
    oh_q   <= oh_d;
    od_q   <= od_d;
    op_q   <= op_d;
    ow_q   <= ow_d;
    done_q <= done_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[pos_q];
  end

  assign out_valid_o          = ov_q;
  assign status_o             = st_q;
  assign fetch_needed_o       = fn_q;
  assign hash_block_address_o = oh_q;
  assign data_block_address_o = od_q;
  assign word_position_o      = op_q;
  assign stored_word_o        = ow_q;
  assign access_done_o        = done_q;

endmodule

@@ tb/tb_interleaved_crc_block_verifier.sv @@
// ----------------------------------------------------------------------------
// tb_interleaved_crc_block_verifier
// self-checking testbench: a behavioral model of the block mapping, the hash
// cache and the crc-32 predicts every result; directed accesses cover range
// errors, fill failures, cache misses and config extremes, then random
// accesses with random idling on both channels
// ----------------------------------------------------------------------------
module tb_interleaved_crc_block_verifier;
  import icbv_pkg::*;

  localparam logic [1:0] KindNone = 2'd3;
  localparam int unsigned WaitSweep = MaxHashWordsDef + 200;
  localparam logic [48:0] AllOnes = {49{1'b1}};

  typedef struct packed {
    logic [1:0]  kind;
    logic        is_write;
    logic [47:0] lb;
    logic [9:0]  fidx;
    logic [31:0] fval;
    logic        ffail;
    logic [7:0]  dbyte;
    logic        dlast;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fetch;
    logic [48:0] haddr;
    logic [48:0] daddr;
    logic [9:0]  pos;
    logic [31:0] word;
    logic        done;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegWordsPerBlock;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  item_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t got;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  interleaved_crc_block_verifier u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (drv.kind),
    .is_write_i          (drv.is_write),
    .logical_block_i     (drv.lb),
    .fill_index_i        (drv.fidx),
    .fill_value_i        (drv.fval),
    .fill_failed_i       (drv.ffail),
    .data_byte_i         (drv.dbyte),
    .data_last_i         (drv.dlast),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (got.status),
    .fetch_needed_o      (got.fetch),
    .hash_block_address_o(got.haddr),
    .data_block_address_o(got.daddr),
    .word_position_o     (got.pos),
    .stored_word_o       (got.word),
    .access_done_o       (got.done)
  );

  // block model state
  logic [10:0] m_wpb = 11'd1024;
  logic [31:0] m_zero = '0;
  logic [48:0] m_count = 49'd1;
  logic [31:0] m_words [MaxHashWordsDef];
  bit          m_written [MaxHashWordsDef];
  logic [48:0] m_cached = AllOnes;
  logic [48:0] m_pending = AllOnes;
  logic [48:0] m_daddr = '0;
  logic [31:0] m_crc = '1;
  logic        m_wr = 1'b0;
  logic [9:0]  m_pos = '0;
  bit          m_active = 1'b0;

  result_t expected_q [$];
  int errors = 0;
  int n_sent = 0;
  logic [7:0] saved_bytes [$];
  logic [47:0] saved_lb = '0;

  function automatic logic [31:0] model_crc(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) v = v[0] ? ((v >> 1) ^ 32'hEDB88320) : (v >> 1);
    return v;
  endfunction

  function automatic void zero_cache();
    for (int i = 0; i < MaxHashWordsDef; i++) begin
      m_words[i] = '0;
      m_written[i] = 1'b1;
    end
  endfunction

  function automatic bit model_step(input item_t it, output result_t r);
    logic [63:0] wpb, chunk, ha, da, ps;
    logic [31:0] crc, w;
    r = '0;
    if (it.kind == KindStart) begin
      wpb = {53'd0, m_wpb};
      if (wpb == 0) wpb = 1;
      if (wpb > MaxHashWordsDef) wpb = MaxHashWordsDef;
      m_crc = '1;
      if ({1'b0, it.lb} >= m_count) begin
        m_active = 1'b0;
        r.status = StatRange;
        r.done = 1'b1;
        return 1'b1;
      end
      chunk = {16'd0, it.lb} / wpb;
      ps = {16'd0, it.lb} % wpb;
      ha = chunk * (wpb + 1);
      da = {16'd0, it.lb} + chunk + 1;
      m_wr = it.is_write;
      m_pos = ps[9:0];
      m_pending = ha[48:0];
      m_daddr = da[48:0];
      m_active = 1'b1;
      r = '{StatOk, m_cached != m_pending, ha[48:0], da[48:0], ps[9:0], 32'd0, 1'b0};
      return 1'b1;
    end
    if (!m_active || it.kind == KindNone) return 1'b0;
    if (it.kind == KindFill) begin
      if (it.ffail) begin
        if (m_wr) begin
          zero_cache();
          m_cached = m_pending;
          return 1'b0;
        end
        m_cached = AllOnes;
        m_active = 1'b0;
        m_crc = '1;
        r = '{StatHashFail, 1'b0, m_pending, m_daddr, m_pos, 32'd0, 1'b1};
        return 1'b1;
      end
      m_words[it.fidx] = it.fval;
      m_written[it.fidx] = 1'b1;
      m_cached = m_pending;
      return 1'b0;
    end
    m_crc = model_crc(m_crc, it.dbyte);
    if (!it.dlast) return 1'b0;
    crc = ~m_crc;
    m_active = 1'b0;
    m_crc = '1;
    if (m_wr) begin
      w = crc ^ m_zero;
      if (m_cached != m_pending) begin
        zero_cache();
        m_cached = m_pending;
      end
      m_words[m_pos] = w;
      m_written[m_pos] = 1'b1;
      r = '{StatOk, 1'b0, m_pending, m_daddr, m_pos, w, 1'b1};
      return 1'b1;
    end
    if (m_cached != m_pending) begin
      r = '{StatHashFail, 1'b0, m_pending, m_daddr, m_pos, 32'd0, 1'b1};
      return 1'b1;
    end
    r = '{((m_words[m_pos] ^ m_zero) == crc) ? StatOk : StatMismatch, 1'b0,
          m_pending, m_daddr, m_pos, 32'd0, 1'b1};
    return 1'b1;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    bit ok;
    result_t r;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= it;
    do begin
      @(negedge clk);
      ok = !in_stall;
      if (ok && model_step(it, r)) expected_q.push_back(r);
      @(posedge clk);
    end while (!ok);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (WaitSweep) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [48:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegWordsPerBlock) m_wpb = val[10:0];
    else if (idx == RegZeroCrc) m_zero = val[31:0];
    else if (idx == RegBlockCount) m_count = val;
  endtask

  task automatic configure(input logic [10:0] wpb, input logic [31:0] z, input logic [48:0] n);
    wait_idle();
    write_reg(RegWordsPerBlock, {38'd0, wpb});
    write_reg(RegZeroCrc, {17'd0, z});
    write_reg(RegBlockCount, n);
  endtask

  function automatic item_t noise_item(input logic [1:0] k);
    item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.kind = k;
    return it;
  endfunction

  // fill_mode: 0 none, 1 fills, 2 failed fill; abandon leaves out the last byte
  task automatic run_access(input bit wr, input logic [47:0] lb, input int nbytes,
                            input int fill_mode, input bit reuse, input bit abandon);
    item_t it;
    logic [7:0] b;
    it = noise_item(KindStart);
    it.is_write = wr;
    it.lb = lb;
    send_item(it);
    if (fill_mode == 2) begin
      it = noise_item(KindFill);
      it.ffail = 1'b1;
      send_item(it);
    end else if (fill_mode == 1) begin
      repeat ($urandom_range(1, 2)) begin
        it = noise_item(KindFill);
        it.ffail = 1'b0;
        send_item(it);
      end
    end
    if (!reuse) begin
      saved_bytes.delete();
      repeat (nbytes) saved_bytes.push_back(8'($urandom));
      saved_lb = lb;
    end
    foreach (saved_bytes[i]) begin
      b = saved_bytes[i];
      if (i == saved_bytes.size() - 1) begin
        if (abandon) return;
        if (m_active && !m_wr && m_cached == m_pending && !m_written[m_pos]) begin
          it = noise_item(KindFill);
          it.ffail = 1'b0;
          it.fidx = m_pos;
          send_item(it);
        end
      end
      it = noise_item(KindData);
      it.dbyte = b;
      it.dlast = (i == saved_bytes.size() - 1);
      send_item(it);
    end
  endtask

  task automatic test_out_of_range();
    configure(11'd1024, 32'd0, 49'd1);
    run_access(1'b0, 48'd1, 2, 0, 1'b0, 1'b0);
    run_access(1'b1, '1, 1, 1, 1'b0, 1'b0);
    send_item(noise_item(KindNone));
    send_item(noise_item(KindFill));
    send_item(noise_item(KindData));
  endtask

  task automatic test_write_read();
    configure(11'd1024, 32'd0, 49'h1_0000_0000_0000);
    saved_bytes = '{8'h00, 8'hFF};
    run_access(1'b1, 48'd0, 2, 0, 1'b1, 1'b0);
    run_access(1'b0, 48'd0, 2, 0, 1'b1, 1'b0);
    saved_bytes = '{8'hFF, 8'h00};
    run_access(1'b0, 48'd0, 2, 0, 1'b1, 1'b0);
    run_access(1'b1, '1, 1, 1, 1'b0, 1'b0);
    run_access(1'b0, 48'd5000, 3, 0, 1'b0, 1'b0);
    run_access(1'b0, 48'd7000, 3, 1, 1'b0, 1'b0);
  endtask

  task automatic test_fill_paths();
    run_access(1'b0, 48'd3, 2, 2, 1'b0, 1'b0);
    run_access(1'b1, 48'd2100, 2, 2, 1'b0, 1'b0);
    run_access(1'b0, 48'd2101, 2, 1, 1'b0, 1'b1);
    run_access(1'b1, 48'd2102, 2, 0, 1'b0, 1'b0);
  endtask

  task automatic test_config_extremes();
    configure(11'd0, 32'hFFFF_FFFF, 49'd100);
    run_access(1'b1, 48'd99, 1, 0, 1'b0, 1'b0);
    run_access(1'b0, 48'd99, 1, 0, 1'b1, 1'b0);
    configure(11'd2047, 32'h1234_5678, {49{1'b1}});
    run_access(1'b1, 48'd1023, 2, 1, 1'b0, 1'b0);
    run_access(1'b0, 48'd1023, 2, 0, 1'b1, 1'b0);
  endtask

  task automatic test_random();
    int acc;
    int sel;
    bit wr;
    logic [47:0] lb;
    logic [48:0] n;
    logic [10:0] wpb;
    acc = 0;
    while (n_sent < 900) begin
      if (acc % 12 == 0) begin
        sel = $urandom_range(0, 5);
        wpb = (sel == 0) ? 11'd1 : (sel == 1) ? 11'd1024 : (sel == 2) ? 11'($urandom)
            : 11'($urandom_range(1, 64));
        sel = $urandom_range(0, 3);
        n = (sel == 0) ? 49'h1_0000_0000_0000 : (sel == 1) ? 49'({$urandom, $urandom})
          : 49'($urandom_range(1, 5000));
        configure(wpb, $urandom, n);
        quiet = ($urandom_range(0, 3) == 0);
      end
      acc++;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        send_item(noise_item(2'($urandom)));
        continue;
      end
      if (sel < 8 && saved_bytes.size() > 0) begin
        run_access(1'b0, saved_lb, 0, ($urandom_range(0, 3) == 0) ? 1 : 0, 1'b1, 1'b0);
        continue;
      end
      wr = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 9);
      lb = (sel == 0) ? 48'({$urandom, $urandom}) : (sel == 1) ? 48'(m_count)
         : (sel == 2) ? 48'(m_count - 1) : 48'($urandom_range(0, 4000));
      sel = $urandom_range(0, 29);
      run_access(wr, lb, $urandom_range(1, 8),
                 (sel == 0) ? 2 : (sel < 12) ? 1 : 0, 1'b0, sel == 29);
    end
  endtask

  always begin
    int n;
    bit t;
    n = quiet ? 0 : $urandom_range(0, 3);
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
    do begin
      @(negedge clk);
      t = out_valid;
      @(posedge clk);
    end while (!t);
  end

  always @(negedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction status %0d", got.status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (got.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, got.status); errors++;
        end
        if (got.fetch !== e.fetch) begin
          $error("fetch_needed exp %0d got %0d", e.fetch, got.fetch); errors++;
        end
        if (got.haddr !== e.haddr) begin
          $error("hash_block_address exp %0h got %0h", e.haddr, got.haddr); errors++;
        end
        if (got.daddr !== e.daddr) begin
          $error("data_block_address exp %0h got %0h", e.daddr, got.daddr); errors++;
        end
        if (got.pos !== e.pos) begin
          $error("word_position exp %0d got %0d", e.pos, got.pos); errors++;
        end
        if (got.word !== e.word) begin
          $error("stored_word exp %0h got %0h", e.word, got.word); errors++;
        end
        if (got.done !== e.done) begin
          $error("access_done exp %0d got %0d", e.done, got.done); errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_interleaved_crc_block_verifier NOT OK");
    $finish;
  end

  initial begin
    foreach (m_written[i]) begin
      m_written[i] = 1'b0;
      m_words[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_out_of_range();
    test_write_read();
    test_fill_paths();
    test_config_extremes();
    test_random();
    wait_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_interleaved_crc_block_verifier OK");
    end else begin
      $display("tb_interleaved_crc_block_verifier NOT OK");
    end
    $finish;
  end

endmodule
